// File: design/ucs_pkg.sv
// Shared types, constants and codes for the URL component splitter.
package ucs_pkg;

    // Longest URL that is parsed; longer ones report too long.
    localparam int MAX_LEN = 4096;
    localparam int POS_W   = $clog2(MAX_LEN + 2);
    localparam int PORT_W  = 17;
    localparam int OUT_POS_W = 13;

    localparam logic [POS_W-1:0]  MAX_POS  = POS_W'(MAX_LEN);
    localparam logic [PORT_W-1:0] PORT_MAX = PORT_W'(65535);

    // Character codes that steer the parse.
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUES   = 8'h3F;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Parse phases; their order matters for the range tests.
    typedef enum logic [3:0] {
        PH_SCHEME_START = 4'd0,
        PH_SCHEME_BODY  = 4'd1,
        PH_SLASH1       = 4'd2,
        PH_SLASH2       = 4'd3,
        PH_PATH         = 4'd4,
        PH_HOST_START   = 4'd5,
        PH_HOST_REG     = 4'd6,
        PH_HOST_V6      = 4'd7,
        PH_V6_AFTER     = 4'd8,
        PH_V6_PORT      = 4'd9,
        PH_V6_BAD       = 4'd10
    } t_phase;

    // Result status codes.
    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_CTRL       = 4'd1,
        ST_PORT_EMPTY = 4'd2,
        ST_PORT_RANGE = 4'd3,
        ST_PORT_CHAR  = 4'd4,
        ST_V6_OPEN    = 4'd5,
        ST_V6_JUNK    = 4'd6,
        ST_AMBIGUOUS  = 4'd7,
        ST_TOO_LONG   = 4'd8
    } t_status;

    // Running parse state for one URL.
    typedef struct packed {
        logic [POS_W-1:0]  position;
        t_phase            phase;
        logic [POS_W-1:0]  scheme_colon_pos;
        logic [POS_W-1:0]  hash_pos;
        logic [POS_W-1:0]  question_pos;
        logic [POS_W-1:0]  last_at_pos;
        logic [POS_W-1:0]  hostport_start;
        logic [POS_W-1:0]  authority_end;
        logic [1:0]        colon_count;
        logic [POS_W-1:0]  first_colon_pos;
        logic [POS_W-1:0]  bracket_close_pos;
        logic              after_bracket_bad;
        logic [PORT_W-1:0] port_accum;
        logic [2:0]        port_digits;
        logic              port_nondigit;
        logic              control_seen;
    } t_pstate;

    // Handshake control handed from the input stage to the datapath.
    typedef struct packed {
        logic step;
        logic last;
    } t_step;

    // One result item.
    typedef struct packed {
        t_status              status;
        logic [OUT_POS_W-1:0] scheme_end;
        logic                 has_authority;
        logic [OUT_POS_W-1:0] at_offset;
        logic [OUT_POS_W-1:0] host_start;
        logic [OUT_POS_W-1:0] host_end;
        logic                 host_is_ipv6;
        logic                 has_port;
        logic [15:0]          port_value;
        logic [OUT_POS_W-1:0] path_start;
        logic [OUT_POS_W-1:0] query_offset;
        logic [OUT_POS_W-1:0] fragment_offset;
    } t_result;

    // State at reset and at the start of every URL.
    function automatic t_pstate pstate_reset();
        t_pstate s;
        s.position          = '0;
        s.phase             = PH_SCHEME_START;
        s.scheme_colon_pos  = '0;
        s.hash_pos          = MAX_POS;
        s.question_pos      = MAX_POS;
        s.last_at_pos       = MAX_POS;
        s.hostport_start    = '0;
        s.authority_end     = '0;
        s.colon_count       = '0;
        s.first_colon_pos   = '0;
        s.bracket_close_pos = MAX_POS;
        s.after_bracket_bad = 1'b0;
        s.port_accum        = '0;
        s.port_digits       = '0;
        s.port_nondigit     = 1'b0;
        s.control_seen      = 1'b0;
        return s;
    endfunction

endpackage

// File: design/ucs_parser.sv
// Per-byte parse state registers and their next-state logic.
module ucs_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ucs_pkg::t_step  i_step,
    input  logic [7:0]      i_byte,
    output ucs_pkg::t_pstate o_next
);
    import ucs_pkg::*;

    t_pstate r_st;
    t_pstate n_st;

    // Start a fresh host analysis at the given offset.
    function automatic t_pstate clear_host(t_pstate s, logic [POS_W-1:0] start);
        t_pstate t;
        t = s;
        t.hostport_start    = start;
        t.colon_count       = '0;
        t.first_colon_pos   = '0;
        t.bracket_close_pos = MAX_POS;
        t.after_bracket_bad = 1'b0;
        t.port_accum        = '0;
        t.port_digits       = '0;
        t.port_nondigit     = 1'b0;
        t.phase             = PH_HOST_START;
        return t;
    endfunction

    // Fold one port character into the accumulator and counters.
    function automatic t_pstate port_char(t_pstate s, logic [7:0] c);
        t_pstate t;
        t = s;
        if (c >= 8'h30 && c <= 8'h39) begin
            if (s.port_digits < 3'd5) begin
                t.port_accum = (s.port_accum << 3) + (s.port_accum << 1)
                             + PORT_W'(c - CH_ZERO);
            end
        end else begin
            t.port_nondigit = 1'b1;
        end
        if (s.port_digits < 3'd6) begin
            t.port_digits = s.port_digits + 3'd1;
        end
        return t;
    endfunction

    // Next state for the byte in the input register.
    always_comb begin
        logic             open_q;
        logic             is_alpha;
        logic             is_scheme;
        logic             host_reg;
        logic [POS_W-1:0] pos;
        logic [7:0]       c;

        n_st     = r_st;
        c        = i_byte;
        pos      = r_st.position;
        open_q   = (r_st.question_pos == MAX_POS) && (r_st.hash_pos == MAX_POS);
        is_alpha = c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
        is_scheme = is_alpha || (c inside {[8'h30:8'h39], 8'h2B, 8'h2D, 8'h2E});
        host_reg = 1'b0;

        if (c == CH_NUL || c == CH_CR || c == CH_LF) begin
            n_st.control_seen = 1'b1;
        end

        if (pos < MAX_POS) begin
            if (c == CH_HASH) begin
                // First hash closes the authority if nothing closed it yet.
                if (r_st.hash_pos == MAX_POS) begin
                    n_st.hash_pos = pos;
                    if (open_q && r_st.phase >= PH_HOST_START &&
                        r_st.authority_end == '0) begin
                        n_st.authority_end = pos;
                    end
                end
            end else if (open_q) begin
                if (c == CH_QUES) begin
                    n_st.question_pos = pos;
                    if (r_st.phase >= PH_HOST_START && r_st.authority_end == '0) begin
                        n_st.authority_end = pos;
                    end
                end else begin
                    case (r_st.phase)
                        PH_SCHEME_START: begin
                            if (is_alpha) begin
                                n_st.phase = PH_SCHEME_BODY;
                            end else if (c == CH_SLASH) begin
                                n_st.phase = PH_SLASH2;
                            end else begin
                                n_st.phase = PH_PATH;
                            end
                        end
                        PH_SCHEME_BODY: begin
                            if (c == CH_COLON) begin
                                n_st.scheme_colon_pos = pos;
                                n_st.phase = PH_SLASH1;
                            end else if (!is_scheme) begin
                                n_st.phase = PH_PATH;
                            end
                        end
                        PH_SLASH1: begin
                            n_st.phase = (c == CH_SLASH) ? PH_SLASH2 : PH_PATH;
                        end
                        PH_SLASH2: begin
                            if (c == CH_SLASH) begin
                                n_st = clear_host(r_st, pos + POS_W'(1));
                            end else begin
                                n_st.phase = PH_PATH;
                            end
                        end
                        PH_PATH: begin
                            n_st.phase = PH_PATH;
                        end
                        default: begin
                            // Inside the authority until a slash closes it.
                            if (r_st.authority_end == '0) begin
                                if (c == CH_SLASH) begin
                                    n_st.authority_end = pos;
                                end else if (c == CH_AT) begin
                                    n_st = clear_host(r_st, pos + POS_W'(1));
                                    n_st.last_at_pos = pos;
                                end else begin
                                    host_reg = (r_st.phase == PH_HOST_REG);
                                    if (r_st.phase == PH_HOST_START) begin
                                        if (c == CH_LBRACK) begin
                                            n_st.phase = PH_HOST_V6;
                                        end else begin
                                            n_st.phase = PH_HOST_REG;
                                            host_reg = 1'b1;
                                        end
                                    end
                                    if (host_reg) begin
                                        // Registered name: colon splits off a port.
                                        if (r_st.colon_count >= 2'd1) begin
                                            n_st = port_char(n_st, c);
                                            if (c == CH_COLON) begin
                                                n_st.colon_count = 2'd2;
                                            end
                                        end else if (c == CH_COLON) begin
                                            n_st.colon_count = 2'd1;
                                            n_st.first_colon_pos = pos;
                                        end
                                    end else begin
                                        case (r_st.phase)
                                            PH_HOST_V6: begin
                                                if (c == CH_RBRACK) begin
                                                    n_st.bracket_close_pos = pos;
                                                    n_st.phase = PH_V6_AFTER;
                                                end
                                            end
                                            PH_V6_AFTER: begin
                                                if (c == CH_COLON) begin
                                                    n_st.colon_count = 2'd1;
                                                    n_st.first_colon_pos = pos;
                                                    n_st.phase = PH_V6_PORT;
                                                end else begin
                                                    n_st.after_bracket_bad = 1'b1;
                                                    n_st.phase = PH_V6_BAD;
                                                end
                                            end
                                            PH_V6_PORT: begin
                                                n_st = port_char(n_st, c);
                                            end
                                            default: begin
                                                n_st.phase = n_st.phase;
                                            end
                                        endcase
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
        end

        // Position stops one past the limit so overflow stays visible.
        if (pos <= MAX_POS) begin
            n_st.position = pos + POS_W'(1);
        end
    end

    // State register; the last byte of a URL returns it to the start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= pstate_reset();
        end else if (i_step.step) begin
            r_st <= i_step.last ? pstate_reset() : n_st;
        end
    end

    assign o_next = n_st;

endmodule

// File: design/ucs_result.sv
// Builds the result item from the final parse state and holds it for output.
module ucs_result (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ucs_pkg::t_pstate i_state,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output ucs_pkg::t_result o_result
);
    import ucs_pkg::*;

    logic    r_out_vld;
    t_result r_res;
    t_result n_res;

    // Port checks in their order of precedence.
    function automatic t_status port_status(t_pstate s);
        t_status st;
        if (s.port_digits == 3'd0) begin
            st = ST_PORT_EMPTY;
        end else if (s.port_digits > 3'd5) begin
            st = ST_PORT_RANGE;
        end else if (s.port_nondigit) begin
            st = ST_PORT_CHAR;
        end else if (s.port_accum > PORT_MAX) begin
            st = ST_PORT_RANGE;
        end else begin
            st = ST_OK;
        end
        return st;
    endfunction

    // Finalize offsets and status.
    always_comb begin
        logic             auth;
        logic             v6;
        logic             hport;
        logic [POS_W-1:0] ae;
        logic [POS_W-1:0] hs;
        logic [POS_W-1:0] he;
        logic [POS_W-1:0] ps;
        logic [POS_W-1:0] at;
        t_status          st;

        auth  = i_state.phase >= PH_HOST_START;
        v6    = auth && (i_state.phase >= PH_HOST_V6);
        ae    = (auth && i_state.authority_end == '0) ? i_state.position
                                                      : i_state.authority_end;
        hport = 1'b0;
        hs    = '0;
        he    = '0;
        at    = MAX_POS;
        st    = ST_OK;

        if (auth) begin
            at = i_state.last_at_pos;
            if (v6) begin
                hs = i_state.hostport_start + POS_W'(1);
                he = i_state.bracket_close_pos;
                hport = (i_state.phase == PH_V6_PORT);
            end else begin
                hs = i_state.hostport_start;
                he = (i_state.colon_count >= 2'd1) ? i_state.first_colon_pos : ae;
                hport = (i_state.colon_count == 2'd1);
            end
        end

        if (i_state.position > MAX_POS) begin
            st = ST_TOO_LONG;
        end else if (i_state.control_seen) begin
            st = ST_CTRL;
        end else if (auth) begin
            if (i_state.phase == PH_HOST_V6) begin
                st = ST_V6_OPEN;
            end else if (v6 && i_state.after_bracket_bad) begin
                st = ST_V6_JUNK;
            end else if (!v6 && i_state.colon_count >= 2'd2) begin
                st = ST_AMBIGUOUS;
            end else if (hport) begin
                st = port_status(i_state);
            end
        end

        if (auth) begin
            ps = ae;
        end else if (i_state.scheme_colon_pos != '0) begin
            ps = i_state.scheme_colon_pos + POS_W'(1);
        end else begin
            ps = '0;
        end

        // Error items carry a status and nothing else.
        n_res = '0;
        n_res.status = st;
        if (st == ST_OK) begin
            n_res.scheme_end      = OUT_POS_W'(i_state.scheme_colon_pos);
            n_res.has_authority   = auth;
            n_res.at_offset       = OUT_POS_W'(at);
            n_res.host_start      = OUT_POS_W'(hs);
            n_res.host_end        = OUT_POS_W'(he);
            n_res.host_is_ipv6    = v6;
            n_res.has_port        = hport;
            n_res.port_value      = hport ? i_state.port_accum[15:0] : 16'd0;
            n_res.path_start      = OUT_POS_W'(ps);
            n_res.query_offset    = OUT_POS_W'(i_state.question_pos);
            n_res.fragment_offset = OUT_POS_W'(i_state.hash_pos);
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_result    = r_res;

endmodule

// File: design/url_component_splitter_unit.sv
// Top level of the streaming URL component splitter.
//
//  Channel   Handshake                  Payload
//  input     i_in_valid / o_in_ready    i_data_byte, i_last_byte
//  output    o_out_valid / i_out_ready  o_status .. o_fragment_offset
//
// One byte is taken every cycle while no last byte waits for a full output; the
// parse state updates from the byte in the input register. A result item is valid
// right after the edge at which its last byte leaves the input register.
// Reset returns the parse state to the start of a URL and empties both stages.
// A stalled result holds only a last byte in the input register; no other bytes
// are taken into the input register or the parse state meanwhile.
module url_component_splitter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_status,
    output logic [12:0] o_scheme_end,
    output logic        o_has_authority,
    output logic [12:0] o_at_offset,
    output logic [12:0] o_host_start,
    output logic [12:0] o_host_end,
    output logic        o_host_is_ipv6,
    output logic        o_has_port,
    output logic [15:0] o_port_value,
    output logic [12:0] o_path_start,
    output logic [12:0] o_query_offset,
    output logic [12:0] o_fragment_offset
);
    import ucs_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       out_free;
    logic       advance;
    t_step      step;
    t_pstate    next_state;
    t_result    result;

    // The registered byte moves on unless it ends a URL and the output is full.
    assign out_free   = !o_out_valid || i_out_ready;
    assign advance    = r_in_vld && (!r_in_last || out_free);
    assign o_in_ready = !r_in_vld || advance;
    assign step.step  = advance;
    assign step.last  = r_in_last;

    // Input register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    ucs_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_next  (next_state)
    );

    ucs_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance && r_in_last),
        .i_state     (next_state),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_status          = result.status;
    assign o_scheme_end      = result.scheme_end;
    assign o_has_authority   = result.has_authority;
    assign o_at_offset       = result.at_offset;
    assign o_host_start      = result.host_start;
    assign o_host_end        = result.host_end;
    assign o_host_is_ipv6    = result.host_is_ipv6;
    assign o_has_port        = result.has_port;
    assign o_port_value      = result.port_value;
    assign o_path_start      = result.path_start;
    assign o_query_offset    = result.query_offset;
    assign o_fragment_offset = result.fragment_offset;

    // A last byte that leaves the input register always yields a result item.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> o_out_valid)
        else $error("last byte did not produce a result item");

    // A held byte stays in the input register unchanged.
    a_hold_stalled_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !advance) |=> (r_in_vld && $stable(r_in_byte)))
        else $error("stalled byte was lost or changed");

    // Error items carry no offsets.
    a_error_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
        (o_scheme_end == '0 && o_path_start == '0 && !o_has_port && !o_has_authority))
        else $error("error item carries component fields");

    // A port only exists inside an authority.
    a_port_needs_authority: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_has_port) |-> o_has_authority)
        else $error("port reported without authority");

endmodule
